// ===== rtl/pds_pkg.sv =====
// Shared types, constants and scan-step logic for the description pragma scanner.
// No dependencies; used by pragma_description_scanner_core.
package pds_pkg;

   localparam int PENDING_DEPTH_DEFAULT = 16;

   localparam logic [3:0] KW_LEN = 4'd7;   // "#pragma"
   localparam logic [3:0] DS_LEN = 4'd11;  // "description"

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      logic [7:0] arg_byte;
      logic       closing;
      logic       found;
      logic       truncated;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_SKIP,
      PH_SLASH,
      PH_LC_REST,
      PH_LC_ENDS,
      PH_POSTC,
      PH_BLK,
      PH_BLK_STAR,
      PH_KW,
      PH_PR_SP,
      PH_DS,
      PH_DS_SP,
      PH_ML_REST,
      PH_ML_ENDS,
      PH_ARG,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      CTL_RUN,
      CTL_CLOSE,
      CTL_FLUSH,
      CTL_LAST
   } ctl_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] kwpos;
      logic       again;
   } step_type;

   function automatic logic is_ws(logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_line_end(logic [7:0] c);
      return (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   function automatic logic is_sp_tab(logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   // "#pragma"
   function automatic logic [7:0] kw_char(logic [3:0] pos);
      logic [7:0] r;
      case (pos)
         4'd0: r = 8'h23;
         4'd1: r = 8'h70;
         4'd2: r = 8'h72;
         4'd3: r = 8'h61;
         4'd4: r = 8'h67;
         4'd5: r = 8'h6D;
         4'd6: r = 8'h61;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // "description"
   function automatic logic [7:0] ds_char(logic [3:0] pos);
      logic [7:0] r;
      case (pos)
         4'd0:  r = 8'h64;
         4'd1:  r = 8'h65;
         4'd2:  r = 8'h73;
         4'd3:  r = 8'h63;
         4'd4:  r = 8'h72;
         4'd5:  r = 8'h69;
         4'd6:  r = 8'h70;
         4'd7:  r = 8'h74;
         4'd8:  r = 8'h69;
         4'd9:  r = 8'h6F;
         4'd10: r = 8'h6E;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // A miss on the first byte after the spaces skips that byte even if it ends the line.
   function automatic phase_type keyword_miss(logic [3:0] pos, logic [7:0] c);
      return ((pos == 4'd0) || !is_line_end(c)) ? PH_ML_REST : PH_ML_ENDS;
   endfunction

   // One pass of the skip/keyword machine; again asks for a re-dispatch on the same byte.
   function automatic step_type scan_step(phase_type ph, logic [3:0] pos, logic [7:0] c);
      step_type r;
      r.phase = ph;
      r.kwpos = pos;
      r.again = 1'b0;
      case (ph)
         PH_SKIP: begin
            if (c == CHAR_SLASH) begin
               r.phase = PH_SLASH;
            end else if (!is_ws(c)) begin
               r.phase = PH_KW;
               r.kwpos = 4'd0;
               r.again = 1'b1;
            end
         end
         PH_SLASH: begin
            if (c == CHAR_SLASH) begin
               r.phase = PH_LC_REST;
            end else if (c == CHAR_STAR) begin
               r.phase = PH_BLK;
            end else begin
               r.phase = PH_POSTC;
               r.again = 1'b1;
            end
         end
         PH_LC_REST: begin
            if (is_line_end(c)) r.phase = PH_LC_ENDS;
         end
         PH_LC_ENDS: begin
            if (!is_line_end(c)) begin
               r.phase = PH_POSTC;
               r.again = 1'b1;
            end
         end
         PH_POSTC: begin
            if (is_ws(c)) begin
               r.phase = PH_SKIP;
            end else begin
               r.phase = PH_KW;
               r.kwpos = 4'd0;
               r.again = 1'b1;
            end
         end
         PH_BLK: begin
            if (c == CHAR_STAR) r.phase = PH_BLK_STAR;
         end
         PH_BLK_STAR: begin
            if (c == CHAR_SLASH) begin
               r.phase = PH_POSTC;
            end else if (c != CHAR_STAR) begin
               r.phase = PH_BLK;
            end
         end
         PH_KW: begin
            if (pos < KW_LEN) begin
               if (c == kw_char(pos)) r.kwpos = pos + 4'd1;
               else r.phase = keyword_miss(pos, c);
            end else if (is_sp_tab(c)) begin
               r.phase = PH_PR_SP;
            end else begin
               r.phase = keyword_miss(pos, c);
            end
         end
         PH_PR_SP: begin
            if (!is_sp_tab(c)) begin
               r.phase = PH_DS;
               r.kwpos = 4'd0;
               r.again = 1'b1;
            end
         end
         PH_DS: begin
            if (pos < DS_LEN) begin
               if (c == ds_char(pos)) r.kwpos = pos + 4'd1;
               else r.phase = keyword_miss(pos, c);
            end else if (is_sp_tab(c)) begin
               r.phase = PH_DS_SP;
            end else begin
               r.phase = keyword_miss(pos, c);
            end
         end
         PH_ML_REST: begin
            if (is_line_end(c)) r.phase = PH_ML_ENDS;
         end
         PH_ML_ENDS: begin
            if (!is_line_end(c)) begin
               r.phase = PH_SKIP;
               r.again = 1'b1;
            end
         end
         PH_DS_SP, PH_ARG, PH_DONE: begin
            r.phase = ph;
         end
         default: begin
            r.phase = PH_SKIP;
            r.again = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/pds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the scanner's held whitespace bytes.
module pds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      // hold read data while no read is issued
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pragma_description_scanner_core.sv =====
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_stall | req_type (text_byte, end_mark)
// rsp     | out       | rsp_valid / rsp_stall | rsp_type (arg_byte, closing, found, truncated)
//
// One byte per cycle while the output is not stalled and no flush or close is pending.
// An argument byte that releases held whitespace bytes starts the first RAM read in its
// transfer cycle; then each held byte is output in turn, and then the byte itself.
// A line end straight after the spaces behind "description" is output as a byte, then a close.
// Reset is synchronous and clears control state only; the held-byte RAM is not cleared,
// since an entry is read only after it has been written.
// A stalled result holds the output register, and the input stalls until it can load.
//
// Top level of the description pragma scanner; depends on pds_pkg and pds_ram.
module pragma_description_scanner_core #(
   parameter int PENDING_DEPTH = pds_pkg::PENDING_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pds_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pds_pkg::rsp_type rsp_data
);
   import pds_pkg::*;

   localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int CW = $clog2(PENDING_DEPTH + 1);

   phase_type   phase_ff, phase_in;
   logic [3:0]  kwpos_ff, kwpos_in;
   logic [CW-1:0] count_ff, count_in;
   logic        overflow_ff, overflow_in;
   ctl_type     ctl_ff, ctl_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [7:0]  held_ff, held_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        can_load;
   logic        load;
   rsp_type     load_data;
   logic        wr_en;
   logic        rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]  rd_data;
   logic [7:0]  c;
   logic        endm;
   step_type    st;

   pds_ram #(
      .WIDTH(8),
      .DEPTH(PENDING_DEPTH)
   ) u_pending_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (c),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign c        = req_data.text_byte;
   assign endm     = req_data.end_mark;
   assign can_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      phase_in    = phase_ff;
      kwpos_in    = kwpos_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      ctl_in      = ctl_ff;
      idx_in      = idx_ff;
      held_in     = held_ff;
      req_stall   = 1'b1;
      load        = 1'b0;
      load_data   = '0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = idx_ff;

      // skip/keyword chain: at most three passes on one byte
      st.phase = phase_ff;
      st.kwpos = kwpos_ff;
      st.again = 1'b1;
      for (int k = 0; k < 3; k++) begin
         if (st.again) st = scan_step(st.phase, st.kwpos, c);
      end

      case (ctl_ff)
         CTL_RUN: begin
            req_stall = !can_load;
            if (req_valid && can_load) begin
               if (phase_ff == PH_DONE) begin
                  if (endm) begin
                     phase_in    = PH_SKIP;
                     kwpos_in    = 4'd0;
                     count_in    = '0;
                     overflow_in = 1'b0;
                  end
               end else if (endm || (c == CHAR_NUL)) begin
                  load                = 1'b1;
                  load_data.closing   = 1'b1;
                  load_data.found     = (phase_ff == PH_ARG);
                  load_data.truncated = overflow_ff;
                  if (endm) begin
                     phase_in    = PH_SKIP;
                     kwpos_in    = 4'd0;
                     count_in    = '0;
                     overflow_in = 1'b0;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  case (phase_ff)
                     PH_DS_SP: begin
                        if (!is_sp_tab(c)) begin
                           load               = 1'b1;
                           load_data.arg_byte = c;
                           if (is_line_end(c)) begin
                              phase_in = PH_DONE;
                              ctl_in   = CTL_CLOSE;
                           end else begin
                              phase_in = PH_ARG;
                              count_in = '0;
                           end
                        end
                     end
                     PH_ARG: begin
                        if (is_line_end(c)) begin
                           load                = 1'b1;
                           load_data.closing   = 1'b1;
                           load_data.found     = 1'b1;
                           load_data.truncated = overflow_ff;
                           phase_in            = PH_DONE;
                        end else if (is_ws(c)) begin
                           if (count_ff < CW'(PENDING_DEPTH)) begin
                              wr_en    = 1'b1;
                              count_in = count_ff + CW'(1);
                           end else begin
                              overflow_in = 1'b1;
                           end
                        end else if (count_ff == '0) begin
                           load               = 1'b1;
                           load_data.arg_byte = c;
                        end else begin
                           // release held whitespace first, then this byte
                           held_in = c;
                           rd_en   = 1'b1;
                           rd_addr = '0;
                           idx_in  = '0;
                           ctl_in  = CTL_FLUSH;
                        end
                     end
                     default: begin
                        phase_in = st.phase;
                        kwpos_in = st.kwpos;
                     end
                  endcase
               end
            end
         end
         CTL_CLOSE: begin
            if (can_load) begin
               load                = 1'b1;
               load_data.closing   = 1'b1;
               load_data.found     = 1'b1;
               load_data.truncated = overflow_ff;
               ctl_in              = CTL_RUN;
            end
         end
         CTL_FLUSH: begin
            if (can_load) begin
               load               = 1'b1;
               load_data.arg_byte = rd_data;
               if ((CW'(idx_ff) + CW'(1)) == count_ff) begin
                  ctl_in = CTL_LAST;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + AW'(1);
                  idx_in  = idx_ff + AW'(1);
               end
            end
         end
         CTL_LAST: begin
            if (can_load) begin
               load               = 1'b1;
               load_data.arg_byte = held_ff;
               count_in           = '0;
               ctl_in             = CTL_RUN;
            end
         end
         default: begin
            ctl_in = CTL_RUN;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_data_in  = load ? load_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SKIP;
         kwpos_ff     <= 4'd0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         ctl_ff       <= CTL_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kwpos_ff     <= kwpos_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_busy_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff != CTL_RUN) |-> req_stall)
      else $error("input taken while a flush or close is pending");

   a_flush_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == CTL_FLUSH) |-> ((count_ff != '0) && ((CW'(idx_ff)) < count_ff)))
      else $error("flush index outside held bytes");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PENDING_DEPTH))
      else $error("held byte count beyond buffer depth");

   a_close_ends_search: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == CTL_CLOSE) |-> (phase_ff == PH_DONE))
      else $error("close pending while search still active");

endmodule
